// ===== rtl/pcsp_pkg.sv =====
// Types, codes and helper functions shared by the PNG chunk stream parser.
package pcsp_pkg;

  typedef enum logic [12:0] {
    PH_SIG    = 13'b0_0000_0000_0001,
    PH_HLEN   = 13'b0_0000_0000_0010,
    PH_HNAME  = 13'b0_0000_0000_0100,
    PH_HDATA  = 13'b0_0000_0000_1000,
    PH_LEN    = 13'b0_0000_0001_0000,
    PH_NAME   = 13'b0_0000_0010_0000,
    PH_SKIP   = 13'b0_0000_0100_0000,
    PH_PAL    = 13'b0_0000_1000_0000,
    PH_DAT    = 13'b0_0001_0000_0000,
    PH_CRC    = 13'b0_0010_0000_0000,
    PH_ENDCRC = 13'b0_0100_0000_0000,
    PH_DONE   = 13'b0_1000_0000_0000,
    PH_ERR    = 13'b1_0000_0000_0000
  } phase_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_PAL  = 2'd2;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_SIGNATURE = 4'd1;
  localparam logic [3:0] ERR_IHDR      = 4'd2;
  localparam logic [3:0] ERR_IEND_LEN  = 4'd3;
  localparam logic [3:0] ERR_PAL_DUP   = 4'd4;
  localparam logic [3:0] ERR_PAL_LEN   = 4'd5;
  localparam logic [3:0] ERR_PAL_LATE  = 4'd6;
  localparam logic [3:0] ERR_CRITICAL  = 4'd7;
  localparam logic [3:0] ERR_NO_DATA   = 4'd8;
  localparam logic [3:0] ERR_NO_PAL    = 4'd9;
  localparam logic [3:0] ERR_TRUNC     = 4'd10;

  localparam logic [31:0] NAME_IHDR = 32'h4948_4452;
  localparam logic [31:0] NAME_IEND = 32'h4945_4E44;
  localparam logic [31:0] NAME_PLTE = 32'h504C_5445;
  localparam logic [31:0] NAME_IDAT = 32'h4944_4154;

  localparam logic [7:0] COLOR_PALETTE = 8'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [9:0] pidx;
    logic [1:0] status;
    logic [3:0] err;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  // Since 4 is 1 modulo 3, summing the base-4 digits keeps the residue.
  function automatic logic div3_ok(input logic [9:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    logic       ok;
    s1 = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} +
         {2'b00, v[7:6]} + {2'b00, v[9:8]};
    s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]};
    case (s2)
      3'd0, 3'd3, 3'd6: ok = 1'b1;
      default:          ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/png_chunk_stream_parser_core.sv =====
// PNG chunk stream parser: byte-serial chunk walker with a registered result.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_data_byte, in_is_last
//   out_    | output    | out_valid/out_stall | out_kind, out_byte, out_palette_index,
//           |           |                     | out_status, out_error_code
//
// One byte is taken per cycle while in_stall is low; each accepted byte gives
// exactly one result in the next cycle, held in the output register. The parse
// state is updated in the cycle of acceptance, so consecutive bytes follow back to back.
// Reset puts the parser in the signature phase with no result pending.
// A stalled output blocks input only while the output register is occupied.
module png_chunk_stream_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [9:0] out_palette_index,
  output logic [1:0] out_status,
  output logic [3:0] out_error_code
);
  import pcsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] name_r, name_nxt;
  logic [9:0]  pal_off_r, pal_off_nxt;
  logic        data_seen_r, data_seen_nxt;
  logic        pal_seen_r, pal_seen_nxt;
  logic        paletted_r, paletted_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [3:0]  error_r, error_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res;

  logic        in_acc;
  logic [3:0]  pos_inc;
  logic [31:0] rem_dec;
  logic [31:0] len_shift;
  logic [31:0] name_shift;
  logic        pal_len_ok;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign pos_inc   = pos_r + 4'd1;
  assign rem_dec   = rem_r - 32'd1;
  assign len_shift = {len_r[23:0], in_data_byte};
  assign name_shift = {name_r[23:0], in_data_byte};
  assign pal_len_ok = (len_r >= 32'd3) && (len_r <= 32'd768) && div3_ok(len_r[9:0]);

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    name_nxt      = name_r;
    pal_off_nxt   = pal_off_r;
    data_seen_nxt = data_seen_r;
    pal_seen_nxt  = pal_seen_r;
    paletted_nxt  = paletted_r;
    status_nxt    = status_r;
    error_nxt     = error_r;
    res.kind      = KIND_NONE;
    res.data      = 8'd0;
    res.pidx      = 10'd0;
    if (status_r == ST_PARSING) begin
      case (phase_r)
        PH_SIG: begin
          if (in_data_byte != sig_byte(pos_r[2:0])) begin
            status_nxt = ST_ERROR;
            error_nxt  = ERR_SIGNATURE;
            phase_nxt  = PH_ERR;
          end else if (pos_inc == 4'd8) begin
            pos_nxt   = 4'd0;
            phase_nxt = PH_HLEN;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_HLEN, PH_LEN: begin
          len_nxt = len_shift;
          if (pos_inc >= 4'd4) begin
            pos_nxt   = 4'd0;
            phase_nxt = (phase_r == PH_HLEN) ? PH_HNAME : PH_NAME;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_HNAME, PH_NAME: begin
          name_nxt = name_shift;
          if (pos_inc >= 4'd4) begin
            pos_nxt = 4'd0;
            if (phase_r == PH_HNAME) begin
              if (len_r != 32'd13 || name_shift != NAME_IHDR) begin
                status_nxt = ST_ERROR;
                error_nxt  = ERR_IHDR;
                phase_nxt  = PH_ERR;
              end else begin
                rem_nxt   = 32'd13;
                phase_nxt = PH_HDATA;
              end
            end else if (name_shift[29]) begin
              // Ancillary chunk: skip its data and CRC.
              rem_nxt   = (len_r == 32'd0) ? 32'd4 : len_r;
              phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_SKIP;
            end else if (name_shift == NAME_IEND) begin
              if (len_r != 32'd0) begin
                status_nxt = ST_ERROR;
                error_nxt  = ERR_IEND_LEN;
                phase_nxt  = PH_ERR;
              end else begin
                rem_nxt   = 32'd4;
                phase_nxt = PH_ENDCRC;
              end
            end else if (name_shift == NAME_PLTE) begin
              if (pal_seen_r) begin
                status_nxt = ST_ERROR;
                error_nxt  = ERR_PAL_DUP;
                phase_nxt  = PH_ERR;
              end else if (!pal_len_ok) begin
                status_nxt = ST_ERROR;
                error_nxt  = ERR_PAL_LEN;
                phase_nxt  = PH_ERR;
              end else if (data_seen_r) begin
                status_nxt = ST_ERROR;
                error_nxt  = ERR_PAL_LATE;
                phase_nxt  = PH_ERR;
              end else begin
                pal_seen_nxt = 1'b1;
                pal_off_nxt  = 10'd0;
                rem_nxt      = len_r;
                phase_nxt    = PH_PAL;
              end
            end else if (name_shift == NAME_IDAT) begin
              data_seen_nxt = 1'b1;
              rem_nxt       = (len_r == 32'd0) ? 32'd4 : len_r;
              phase_nxt     = (len_r == 32'd0) ? PH_CRC : PH_DAT;
            end else begin
              status_nxt = ST_ERROR;
              error_nxt  = ERR_CRITICAL;
              phase_nxt  = PH_ERR;
            end
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_HDATA: begin
          if (rem_r == 32'd4) begin
            paletted_nxt = (in_data_byte == COLOR_PALETTE);
          end
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            rem_nxt   = 32'd4;
            phase_nxt = PH_CRC;
          end
        end
        PH_SKIP, PH_PAL, PH_DAT: begin
          if (phase_r == PH_PAL) begin
            res.kind    = KIND_PAL;
            res.data    = in_data_byte;
            res.pidx    = pal_off_r;
            pal_off_nxt = pal_off_r + 10'd1;
          end else if (phase_r == PH_DAT) begin
            res.kind = KIND_DATA;
            res.data = in_data_byte;
          end
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            rem_nxt   = 32'd4;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            pos_nxt   = 4'd0;
            len_nxt   = 32'd0;
            name_nxt  = 32'd0;
            phase_nxt = PH_LEN;
          end
        end
        PH_ENDCRC: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            if (!data_seen_r) begin
              status_nxt = ST_ERROR;
              error_nxt  = ERR_NO_DATA;
              phase_nxt  = PH_ERR;
            end else if (paletted_r && !pal_seen_r) begin
              status_nxt = ST_ERROR;
              error_nxt  = ERR_NO_PAL;
              phase_nxt  = PH_ERR;
            end else begin
              status_nxt = ST_OK;
              error_nxt  = ERR_NONE;
              phase_nxt  = PH_DONE;
            end
          end
        end
        default: begin
          status_nxt = ST_ERROR;
          error_nxt  = ERR_TRUNC;
          phase_nxt  = PH_ERR;
        end
      endcase
      // A stream that ends before IEND is complete counts as truncated.
      if (status_nxt == ST_PARSING && in_is_last) begin
        status_nxt = ST_ERROR;
        error_nxt  = ERR_TRUNC;
        phase_nxt  = PH_ERR;
      end
    end
    res.status = status_nxt;
    res.err    = error_nxt;
  end

  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      pos_r       <= 4'd0;
      rem_r       <= 32'd0;
      len_r       <= 32'd0;
      name_r      <= 32'd0;
      pal_off_r   <= 10'd0;
      data_seen_r <= 1'b0;
      pal_seen_r  <= 1'b0;
      paletted_r  <= 1'b0;
      status_r    <= ST_PARSING;
      error_r     <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        rem_r       <= rem_nxt;
        len_r       <= len_nxt;
        name_r      <= name_nxt;
        pal_off_r   <= pal_off_nxt;
        data_seen_r <= data_seen_nxt;
        pal_seen_r  <= pal_seen_nxt;
        paletted_r  <= paletted_nxt;
        status_r    <= status_nxt;
        error_r     <= error_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_byte          = res_r.data;
  assign out_palette_index = res_r.pidx;
  assign out_status        = res_r.status;
  assign out_error_code    = res_r.err;

  a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> (out_error_code == ERR_NONE))
    else $error("finished result carries an error code");

  a_parsing_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PARSING) |-> (out_error_code == ERR_NONE))
    else $error("error code reported while still parsing");

  a_pal_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PAL) |-> (out_palette_index < 10'd768))
    else $error("palette index beyond palette size");

  a_sticky_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && status_r != ST_PARSING) |=> (out_kind == KIND_NONE && out_status == $past(status_r)))
    else $error("byte emitted after the parse ended");

  a_done_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (data_seen_r && status_r == ST_OK))
    else $error("stream finished without image data");

endmodule

// ===== tb/sv/png_chunk_stream_parser_core_tb.sv =====
// Testbench for the PNG chunk stream parser: one random PNG stream, checked against a byte model.
`timescale 1ns / 100ps

import pcsp_pkg::*;

localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

class parse_scoreboard;
  phase_t      stage;
  logic [3:0]  step_count;
  logic [31:0] bytes_left;
  logic [31:0] len_acc;
  logic [31:0] name_acc;
  logic [9:0]  pal_pos;
  logic        idat_seen;
  logic        plte_seen;
  logic        paletted;
  logic [1:0]  done_status;
  logic [3:0]  done_err;
  result_t     expected_results[$];
  int          failures;

  function new();
    stage       = PH_SIG;
    step_count  = '0;
    bytes_left  = '0;
    len_acc     = '0;
    name_acc    = '0;
    pal_pos     = '0;
    idat_seen   = 1'b0;
    plte_seen   = 1'b0;
    paletted    = 1'b0;
    done_status = ST_PARSING;
    done_err    = ERR_NONE;
    failures    = 0;
  endfunction

  function int outstanding();
    return expected_results.size();
  endfunction

  function void stop_with(logic [3:0] code);
    done_status = ST_ERROR;
    done_err    = code;
    stage       = PH_ERR;
  endfunction

  function void enter_crc();
    bytes_left = 32'd4;
    stage      = PH_CRC;
  endfunction

  function void open_chunk_data(phase_t next_stage);
    bytes_left = len_acc;
    if (len_acc == 32'd0) begin
      enter_crc();
    end else begin
      stage = next_stage;
    end
  endfunction

  // Works out the result of one accepted request and queues it.
  function void note_byte(logic [7:0] b, logic last);
    result_t r;
    r = '0;
    if (done_status == ST_PARSING) begin
      case (stage)
        PH_SIG: begin
          if (b != PNG_MAGIC[8*(7-step_count[2:0]) +: 8]) begin
            stop_with(ERR_SIGNATURE);
          end else begin
            step_count = step_count + 4'd1;
            if (step_count == 4'd8) begin
              step_count = '0;
              stage      = PH_HLEN;
            end
          end
        end
        PH_HLEN, PH_LEN: begin
          len_acc    = {len_acc[23:0], b};
          step_count = step_count + 4'd1;
          if (step_count >= 4'd4) begin
            step_count = '0;
            stage      = (stage == PH_HLEN) ? PH_HNAME : PH_NAME;
          end
        end
        PH_HNAME, PH_NAME: begin
          name_acc   = {name_acc[23:0], b};
          step_count = step_count + 4'd1;
          if (step_count >= 4'd4) begin
            step_count = '0;
            if (stage == PH_HNAME) begin
              if (len_acc != 32'd13 || name_acc != NAME_IHDR) begin
                stop_with(ERR_IHDR);
              end else begin
                bytes_left = 32'd13;
                stage      = PH_HDATA;
              end
            end else if (name_acc[29]) begin
              // Lowercase first letter marks an ancillary chunk.
              open_chunk_data(PH_SKIP);
            end else if (name_acc == NAME_IEND) begin
              if (len_acc != 32'd0) begin
                stop_with(ERR_IEND_LEN);
              end else begin
                bytes_left = 32'd4;
                stage      = PH_ENDCRC;
              end
            end else if (name_acc == NAME_PLTE) begin
              if (plte_seen) begin
                stop_with(ERR_PAL_DUP);
              end else if ((len_acc % 3) != 0 || len_acc < 3 || len_acc > 768) begin
                stop_with(ERR_PAL_LEN);
              end else if (idat_seen) begin
                stop_with(ERR_PAL_LATE);
              end else begin
                plte_seen = 1'b1;
                pal_pos   = '0;
                open_chunk_data(PH_PAL);
              end
            end else if (name_acc == NAME_IDAT) begin
              idat_seen = 1'b1;
              open_chunk_data(PH_DAT);
            end else begin
              stop_with(ERR_CRITICAL);
            end
          end
        end
        PH_HDATA: begin
          // Color type sits at data offset 9, when four bytes are still to come.
          if (bytes_left == 32'd4) paletted = (b == COLOR_PALETTE);
          bytes_left = bytes_left - 32'd1;
          if (bytes_left == 32'd0) enter_crc();
        end
        PH_SKIP, PH_PAL, PH_DAT: begin
          if (stage == PH_PAL) begin
            r.kind  = KIND_PAL;
            r.data  = b;
            r.pidx  = pal_pos;
            pal_pos = pal_pos + 10'd1;
          end else if (stage == PH_DAT) begin
            r.kind = KIND_DATA;
            r.data = b;
          end
          bytes_left = bytes_left - 32'd1;
          if (bytes_left == 32'd0) enter_crc();
        end
        PH_CRC: begin
          bytes_left = bytes_left - 32'd1;
          if (bytes_left == 32'd0) begin
            step_count = '0;
            len_acc    = '0;
            name_acc   = '0;
            stage      = PH_LEN;
          end
        end
        PH_ENDCRC: begin
          bytes_left = bytes_left - 32'd1;
          if (bytes_left == 32'd0) begin
            if (!idat_seen) begin
              stop_with(ERR_NO_DATA);
            end else if (paletted && !plte_seen) begin
              stop_with(ERR_NO_PAL);
            end else begin
              done_status = ST_OK;
              done_err    = ERR_NONE;
              stage       = PH_DONE;
            end
          end
        end
        default: stop_with(ERR_TRUNC);
      endcase
      if (done_status == ST_PARSING && last) stop_with(ERR_TRUNC);
    end
    r.status = done_status;
    r.err    = done_err;
    expected_results.push_back(r);
  endfunction

  function void flag_field(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    failures++;
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0d byte %0d index %0d status %0d error %0d",
               $time, got.kind, got.data, got.pidx, got.status, got.err);
      failures++;
      return;
    end
    want = expected_results.pop_front();
    if (got.kind   != want.kind)   flag_field("out_kind", want.kind, got.kind);
    if (got.data   != want.data)   flag_field("out_byte", want.data, got.data);
    if (got.pidx   != want.pidx)   flag_field("out_palette_index", want.pidx, got.pidx);
    if (got.status != want.status) flag_field("out_status", want.status, got.status);
    if (got.err    != want.err)    flag_field("out_error_code", want.err, got.err);
  endfunction
endclass

module png_chunk_stream_parser_core_tb;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_is_last;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [9:0] out_palette_index;
  logic [1:0] out_status;
  logic [3:0] out_error_code;

  parse_scoreboard sb;
  logic [8:0]      file_q[$];   // {is_last, data byte}
  int unsigned     cycle_count;

  png_chunk_stream_parser_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_palette_index(out_palette_index),
    .out_status       (out_status),
    .out_error_code   (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Receiver stall pattern: free, light, heavy and periodic stretches in turn.
  always @(negedge clk) begin
    case (cycle_count[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_count[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({out_kind, out_byte, out_palette_index, out_status, out_error_code});
      if (in_valid && !in_stall) sb.note_byte(in_data_byte, in_is_last);
    end
  end

  function automatic void add_byte(logic [7:0] b);
    file_q.push_back({1'b0, b});
  endfunction

  function automatic void add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
  endfunction

  function automatic void add_chunk(logic [31:0] name, int unsigned len);
    add_word(len);
    add_word(name);
    repeat (len) add_byte(8'($urandom));
    repeat (4) add_byte(8'($urandom));
  endfunction

  // Builds one PNG file; the tail is picked at random so that a seed can
  // end on any of several success or error paths.
  function automatic void build_file();
    int unsigned ending;
    int unsigned target;
    int unsigned len;
    int unsigned idx;
    int unsigned trailing;
    logic        want_pal;
    logic        want_plte;
    logic        want_idat;
    logic [7:0]  b;
    logic [31:0] name;

    ending    = $urandom_range(0, 19);
    want_pal  = 1'($urandom_range(0, 1));
    want_plte = want_pal ? ($urandom_range(0, 5) != 0) : 1'($urandom_range(0, 1));
    want_idat = ($urandom_range(0, 9) != 0);
    target    = $urandom_range(620, 700);

    for (int i = 0; i < 8; i++) begin
      b = PNG_MAGIC[8*(7-i) +: 8];
      if (ending == 19 && i == 7 - (cycle_count % 8)) b = b ^ (8'd1 << $urandom_range(0, 7));
      add_byte(b);
    end

    // Header chunk; color type at data offset 9.
    if (ending == 18) begin
      add_word($urandom_range(0, 1) ? 32'd12 : $urandom);
    end else begin
      add_word(32'd13);
    end
    add_word((ending == 17) ? (NAME_IHDR ^ (32'd1 << $urandom_range(0, 31))) : NAME_IHDR);
    for (int i = 0; i < 13; i++) begin
      b = 8'($urandom);
      if (i == 9) begin
        if (want_pal) b = COLOR_PALETTE;
        else if (b == COLOR_PALETTE) b = 8'd6;
      end
      add_byte(b);
    end
    repeat (4) add_byte(8'($urandom));

    // Empty ancillary chunk, palette, a short data chunk with extreme bytes and an empty one.
    add_chunk({8'h74 | 8'h20, 24'h45_5874}, 0);
    if (want_plte) add_chunk(NAME_PLTE, ($urandom_range(0, 7) == 0) ? 768 : 3 * $urandom_range(1, 16));
    if (want_idat) begin
      add_word(32'd2);
      add_word(NAME_IDAT);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_word(32'hFFFF_0000);
      add_chunk(NAME_IDAT, 0);
    end

    while (file_q.size() < target) begin
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
      if (want_idat && $urandom_range(0, 2) != 0) begin
        add_chunk(NAME_IDAT, len);
      end else begin
        name = $urandom;
        name[29] = 1'b1;
        add_chunk(name, len);
      end
    end

    case (ending)
      9, 10: begin
        add_word(($urandom_range(0, 1) != 0) ? $urandom_range(1, 255) : ($urandom | 32'h100));
        add_word(NAME_IEND);
      end
      11: begin
        add_chunk(NAME_PLTE, 3 * $urandom_range(1, 20));
        add_chunk(NAME_IEND, 0);
      end
      12: begin
        case ($urandom_range(0, 3))
          0:       len = 0;
          1:       len = 771;
          2:       len = $urandom | 32'h400;
          default: len = 3 * $urandom_range(0, 255) + $urandom_range(1, 2);
        endcase
        add_word(len);
        add_word(NAME_PLTE);
      end
      13: begin
        name = $urandom;
        name[29] = 1'b0;
        add_chunk(($urandom_range(0, 1) != 0) ? NAME_IHDR : name, 4);
        add_chunk(NAME_IEND, 0);
      end
      14, 15: begin
        idx = $urandom_range(40, file_q.size() - 1);
        file_q[idx] = file_q[idx] | 9'h100;
        add_chunk(NAME_IEND, 0);
      end
      16: ;  // stream simply stops inside the chunk sequence
      default: add_chunk(NAME_IEND, 0);
    endcase

    // Bytes after the end are ignored by the parser; the last one closes the file.
    trailing = $urandom_range(3, 12);
    repeat (trailing) file_q.push_back({1'($urandom_range(0, 1)), 8'($urandom)});
    file_q[file_q.size() - 1] = file_q[file_q.size() - 1] | 9'h100;
  endfunction

  task automatic send_file();
    int unsigned pos;
    int unsigned burst;
    int unsigned gap;
    logic        drained_once;
    pos = 0;
    drained_once = 1'b0;
    while (pos < file_q.size()) begin
      burst = $urandom_range(1, 48);
      while (burst > 0 && pos < file_q.size()) begin
        in_valid <= 1'b1;
        {in_is_last, in_data_byte} <= file_q[pos];
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        pos++;
        burst--;
      end
      // Let the parser empty out now and then, and surely once midway.
      if ((!drained_once && pos >= file_q.size() / 2) || $urandom_range(0, 5) == 0) begin
        drained_once = 1'b1;
        while (sb.outstanding() != 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        in_valid     <= 1'b0;
        in_data_byte <= 8'($urandom);
        @(negedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_is_last   = 1'b0;
    sb = new();
    build_file();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_file();
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
    $display("CHECK FAILED");
    $finish;
  end
endmodule
